>>> hw/rtl/cdfa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cell dipole field accumulator package
// Shared widths, constants, function codes and controller/datapath types.
// ----------------------------------------------------------------------------
package cdfa_pkg;

  localparam int FUNC_W = 2;
  localparam int MAG_W  = 32;
  localparam int VOL_W  = 24;
  localparam int TEN_W  = 32;
  localparam int OUT_W  = 48;
  localparam int SUM_W  = 64;
  localparam int SELF_W = 48;
  localparam int ACC_W  = 46;
  localparam int XM_W   = 53;
  localparam int DIV_BITS = 43;
  localparam int CNT_W  = 6;

  // Item function codes.
  localparam logic [FUNC_W-1:0] FUNC_START = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_NEIGH = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_END   = 2'd2;

  // round(8*pi/3 * 2^28) and round(0.927400915 * 2^32).
  localparam logic [31:0] SELF_K  = 32'd2248839617;
  localparam logic [31:0] SCALE_K = 32'd3983156600;

  localparam logic signed [SUM_W-1:0] CLAMP_POS = 64'sd1125899906842624;
  localparam logic signed [SUM_W-1:0] CLAMP_NEG = -64'sd1125899906842624;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    DP_NOP,
    DP_CAPTURE,
    DP_SELF_MUL,
    DP_DIV_LOAD,
    DP_DIV_STEP,
    DP_SELF_WR,
    DP_NB_MUL,
    DP_NB_ACC,
    DP_NB_SAT,
    DP_SC_PREP,
    DP_SC_LO,
    DP_SC_HI,
    DP_SC_FIN
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] comp;
    logic [1:0] col;
    logic       demag;
  } cdfa_cmd_t;

  typedef struct packed {
    logic div_last;
  } cdfa_sts_t;

endpackage

>>> hw/rtl/cdfa_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cell dipole field accumulator input channel
// Valid/ready channel carrying one start, neighbour or end item.
// ----------------------------------------------------------------------------
interface cdfa_in_if;
  logic                              valid;
  logic                              ready;
  logic [cdfa_pkg::FUNC_W-1:0]       func;
  logic signed [cdfa_pkg::MAG_W-1:0] mag_x;
  logic signed [cdfa_pkg::MAG_W-1:0] mag_y;
  logic signed [cdfa_pkg::MAG_W-1:0] mag_z;
  logic [cdfa_pkg::VOL_W-1:0]        cell_volume;
  logic signed [cdfa_pkg::TEN_W-1:0] t_xx;
  logic signed [cdfa_pkg::TEN_W-1:0] t_xy;
  logic signed [cdfa_pkg::TEN_W-1:0] t_xz;
  logic signed [cdfa_pkg::TEN_W-1:0] t_yy;
  logic signed [cdfa_pkg::TEN_W-1:0] t_yz;
  logic signed [cdfa_pkg::TEN_W-1:0] t_zz;

  modport source (
    output valid, func, mag_x, mag_y, mag_z, cell_volume,
           t_xx, t_xy, t_xz, t_yy, t_yz, t_zz,
    input  ready
  );
  modport sink (
    input  valid, func, mag_x, mag_y, mag_z, cell_volume,
           t_xx, t_xy, t_xz, t_yy, t_yz, t_zz,
    output ready
  );
endinterface

>>> hw/rtl/cdfa_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cell dipole field accumulator result channel
// Valid/ready channel carrying the dipole and demagnetising fields.
// ----------------------------------------------------------------------------
interface cdfa_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [cdfa_pkg::OUT_W-1:0] field_x;
  logic signed [cdfa_pkg::OUT_W-1:0] field_y;
  logic signed [cdfa_pkg::OUT_W-1:0] field_z;
  logic signed [cdfa_pkg::OUT_W-1:0] demag_x;
  logic signed [cdfa_pkg::OUT_W-1:0] demag_y;
  logic signed [cdfa_pkg::OUT_W-1:0] demag_z;

  modport source (
    output valid, field_x, field_y, field_z, demag_x, demag_y, demag_z,
    input  ready
  );
  modport sink (
    input  valid, field_x, field_y, field_z, demag_x, demag_y, demag_z,
    output ready
  );
endinterface

>>> hw/rtl/cdfa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cell dipole field accumulator controller
// Sequences the shared multiplier, divider and scaler and owns result valid.
// ----------------------------------------------------------------------------
module cdfa_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [cdfa_pkg::FUNC_W-1:0] in_func,
  output logic                        in_ready,
  input  logic                        out_ready,
  output logic                        out_valid,
  output cdfa_pkg::cdfa_cmd_t         cmd,
  input  cdfa_pkg::cdfa_sts_t         sts
);

  typedef enum logic [12:0] {
    S_IDLE     = 13'b0000000000001,
    S_SELF_MUL = 13'b0000000000010,
    S_DIV_LOAD = 13'b0000000000100,
    S_DIV_STEP = 13'b0000000001000,
    S_SELF_WR  = 13'b0000000010000,
    S_NB_MUL   = 13'b0000000100000,
    S_NB_ACC   = 13'b0000001000000,
    S_NB_SAT   = 13'b0000010000000,
    S_END_WAIT = 13'b0000100000000,
    S_SC_PREP  = 13'b0001000000000,
    S_SC_LO    = 13'b0010000000000,
    S_SC_HI    = 13'b0100000000000,
    S_SC_FIN   = 13'b1000000000000
  } ctrl_state_t;

  ctrl_state_t state, state_next;
  logic [1:0]  comp, comp_next;
  logic [1:0]  col, col_next;
  logic        demag, demag_next;
  logic        out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      comp      <= 2'd0;
      col       <= 2'd0;
      demag     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      comp      <= comp_next;
      col       <= col_next;
      demag     <= demag_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    comp_next      = comp;
    col_next       = col;
    demag_next     = demag;
    out_valid_next = out_valid && !out_ready;
    in_ready       = (state == S_IDLE);
    cmd.op         = cdfa_pkg::DP_NOP;
    cmd.comp       = comp;
    cmd.col        = col;
    cmd.demag      = demag;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = cdfa_pkg::DP_CAPTURE;
          comp_next  = 2'd0;
          col_next   = 2'd0;
          demag_next = 1'b0;
          case (in_func)
            cdfa_pkg::FUNC_START: state_next = S_SELF_MUL;
            cdfa_pkg::FUNC_NEIGH: state_next = S_NB_MUL;
            cdfa_pkg::FUNC_END:   state_next = S_END_WAIT;
            default:              state_next = S_IDLE;
          endcase
        end
      end
      S_SELF_MUL: begin
        cmd.op     = cdfa_pkg::DP_SELF_MUL;
        state_next = S_DIV_LOAD;
      end
      S_DIV_LOAD: begin
        cmd.op     = cdfa_pkg::DP_DIV_LOAD;
        state_next = S_DIV_STEP;
      end
      S_DIV_STEP: begin
        cmd.op = cdfa_pkg::DP_DIV_STEP;
        if (sts.div_last) begin
          state_next = S_SELF_WR;
        end
      end
      S_SELF_WR: begin
        cmd.op = cdfa_pkg::DP_SELF_WR;
        if (comp == 2'd2) begin
          state_next = S_IDLE;
        end else begin
          comp_next  = comp + 2'd1;
          state_next = S_SELF_MUL;
        end
      end
      S_NB_MUL: begin
        cmd.op     = cdfa_pkg::DP_NB_MUL;
        state_next = S_NB_ACC;
      end
      S_NB_ACC: begin
        cmd.op = cdfa_pkg::DP_NB_ACC;
        if (col == 2'd2) begin
          state_next = S_NB_SAT;
        end else begin
          col_next   = col + 2'd1;
          state_next = S_NB_MUL;
        end
      end
      S_NB_SAT: begin
        cmd.op   = cdfa_pkg::DP_NB_SAT;
        col_next = 2'd0;
        if (comp == 2'd2) begin
          state_next = S_IDLE;
        end else begin
          comp_next  = comp + 2'd1;
          state_next = S_NB_MUL;
        end
      end
      S_END_WAIT: begin
        if (!out_valid) begin
          state_next = S_SC_PREP;
        end
      end
      S_SC_PREP: begin
        cmd.op     = cdfa_pkg::DP_SC_PREP;
        state_next = S_SC_LO;
      end
      S_SC_LO: begin
        cmd.op     = cdfa_pkg::DP_SC_LO;
        state_next = S_SC_HI;
      end
      S_SC_HI: begin
        cmd.op     = cdfa_pkg::DP_SC_HI;
        state_next = S_SC_FIN;
      end
      S_SC_FIN: begin
        cmd.op = cdfa_pkg::DP_SC_FIN;
        if (comp == 2'd2) begin
          comp_next = 2'd0;
          if (demag) begin
            out_valid_next = 1'b1;
            state_next     = S_IDLE;
          end else begin
            demag_next = 1'b1;
            state_next = S_SC_PREP;
          end
        end else begin
          comp_next  = comp + 2'd1;
          state_next = S_SC_PREP;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_valid_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_SC_FIN))
    else $error("result valid raised outside the final scaling step");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (state == S_SC_PREP || state == S_SC_LO || state == S_SC_HI ||
     state == S_SC_FIN) |-> !out_valid)
    else $error("scaling while an earlier result is still held");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    (comp != 2'd3) && (col != 2'd3))
    else $error("component or column index out of range");

  a_div_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV_STEP && sts.div_last) |=> (state == S_SELF_WR))
    else $error("divider finished without writing the self term");

endmodule

>>> hw/rtl/cdfa_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cell dipole field accumulator datapath
// Item registers, shared multiplier, radix-2 divider, sums and result register.
// ----------------------------------------------------------------------------
module cdfa_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  cdfa_pkg::cdfa_cmd_t                cmd,
  output cdfa_pkg::cdfa_sts_t                sts,
  input  logic signed [cdfa_pkg::MAG_W-1:0]  in_mag_x,
  input  logic signed [cdfa_pkg::MAG_W-1:0]  in_mag_y,
  input  logic signed [cdfa_pkg::MAG_W-1:0]  in_mag_z,
  input  logic [cdfa_pkg::VOL_W-1:0]         in_volume,
  input  logic signed [cdfa_pkg::TEN_W-1:0]  in_t_xx,
  input  logic signed [cdfa_pkg::TEN_W-1:0]  in_t_xy,
  input  logic signed [cdfa_pkg::TEN_W-1:0]  in_t_xz,
  input  logic signed [cdfa_pkg::TEN_W-1:0]  in_t_yy,
  input  logic signed [cdfa_pkg::TEN_W-1:0]  in_t_yz,
  input  logic signed [cdfa_pkg::TEN_W-1:0]  in_t_zz,
  output logic signed [cdfa_pkg::OUT_W-1:0]  field_x,
  output logic signed [cdfa_pkg::OUT_W-1:0]  field_y,
  output logic signed [cdfa_pkg::OUT_W-1:0]  field_z,
  output logic signed [cdfa_pkg::OUT_W-1:0]  demag_x,
  output logic signed [cdfa_pkg::OUT_W-1:0]  demag_y,
  output logic signed [cdfa_pkg::OUT_W-1:0]  demag_z
);

  localparam logic [2:0] T_XX = 3'd0;
  localparam logic [2:0] T_XY = 3'd1;
  localparam logic [2:0] T_XZ = 3'd2;
  localparam logic [2:0] T_YY = 3'd3;
  localparam logic [2:0] T_YZ = 3'd4;
  localparam logic [2:0] T_ZZ = 3'd5;

  // Maps a row and column of the symmetric tensor onto its stored entry.
  function automatic logic [2:0] tens_idx(input logic [1:0] row, input logic [1:0] col);
    logic [3:0] rc;
    rc = {row, col};
    case (rc)
      4'h0:    tens_idx = T_XX;
      4'h1:    tens_idx = T_XY;
      4'h2:    tens_idx = T_XZ;
      4'h4:    tens_idx = T_XY;
      4'h5:    tens_idx = T_YY;
      4'h6:    tens_idx = T_YZ;
      4'h8:    tens_idx = T_XZ;
      4'h9:    tens_idx = T_YZ;
      4'hA:    tens_idx = T_ZZ;
      default: tens_idx = T_XX;
    endcase
  endfunction

  // Captured item.
  logic signed [cdfa_pkg::MAG_W-1:0]  mag [3];
  logic [cdfa_pkg::VOL_W-1:0]         vol;
  logic signed [cdfa_pkg::TEN_W-1:0]  tens [6];

  // Block state.
  logic signed [cdfa_pkg::SUM_W-1:0]  neighbour_sum [3];
  logic signed [cdfa_pkg::SELF_W-1:0] self_term [3];

  // Working registers.
  logic signed [65:0]                 prod;
  logic [cdfa_pkg::DIV_BITS-1:0]      nq;
  logic [cdfa_pkg::VOL_W-1:0]         rem;
  logic [cdfa_pkg::CNT_W-1:0]         div_cnt;
  logic signed [cdfa_pkg::ACC_W-1:0]  acc;
  logic [cdfa_pkg::XM_W-1:0]          xm;
  logic                               xneg;
  logic [32:0]                        lo_part;
  logic signed [cdfa_pkg::OUT_W-1:0]  field_out [3];
  logic signed [cdfa_pkg::OUT_W-1:0]  demag_out [3];

  // Combinational helpers.
  logic [1:0]                         mag_idx;
  logic signed [cdfa_pkg::MAG_W-1:0]  mag_sel;
  logic [cdfa_pkg::MAG_W-1:0]         mag_abs;
  logic signed [cdfa_pkg::TEN_W-1:0]  tens_sel;
  logic signed [32:0]                 mul_a;
  logic signed [32:0]                 mul_b;
  logic                               mul_en;
  logic signed [cdfa_pkg::SUM_W-1:0]  sum_sel;
  logic signed [cdfa_pkg::SELF_W-1:0] self_sel;
  logic [63:0]                        num_sum;
  logic [cdfa_pkg::VOL_W:0]           trial;
  logic                               trial_ge;
  logic [cdfa_pkg::SELF_W-1:0]        q_ext;
  logic signed [65:0]                 prod_r;
  logic signed [cdfa_pkg::ACC_W-1:0]  red;
  logic signed [64:0]                 sat_sum;
  logic signed [cdfa_pkg::SUM_W-1:0]  sat_val;
  logic signed [51:0]                 s_cl;
  logic signed [53:0]                 s_ext;
  logic signed [53:0]                 self_ext;
  logic signed [53:0]                 x_val;
  logic [53:0]                        x_abs;
  logic [64:0]                        lo_sum;
  logic [53:0]                        r_sum;
  logic [53:0]                        r_sh;
  logic [53:0]                        r_neg;
  logic signed [cdfa_pkg::OUT_W-1:0]  fin_val;

  always_comb begin
    mag_idx  = (cmd.op == cdfa_pkg::DP_NB_MUL) ? cmd.col : cmd.comp;
    mag_sel  = mag[mag_idx];
    mag_abs  = mag_sel[cdfa_pkg::MAG_W-1] ? (~mag_sel + 32'd1) : mag_sel;
    tens_sel = tens[tens_idx(cmd.comp, cmd.col)];
    sum_sel  = neighbour_sum[cmd.comp];
    self_sel = self_term[cmd.comp];

    mul_en = 1'b1;
    case (cmd.op)
      cdfa_pkg::DP_SELF_MUL: begin
        mul_a = {1'b0, mag_abs};
        mul_b = {1'b0, cdfa_pkg::SELF_K};
      end
      cdfa_pkg::DP_NB_MUL: begin
        mul_a = {mag_sel[cdfa_pkg::MAG_W-1], mag_sel};
        mul_b = {tens_sel[cdfa_pkg::TEN_W-1], tens_sel};
      end
      cdfa_pkg::DP_SC_LO: begin
        mul_a = {1'b0, xm[31:0]};
        mul_b = {1'b0, cdfa_pkg::SCALE_K};
      end
      cdfa_pkg::DP_SC_HI: begin
        mul_a = {12'd0, xm[cdfa_pkg::XM_W-1:32]};
        mul_b = {1'b0, cdfa_pkg::SCALE_K};
      end
      default: begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b0;
      end
    endcase

    // Rounded numerator (P + V*2^19) / 2^20; the divide by V follows bit by bit.
    num_sum  = prod[63:0] + {21'd0, vol, 19'd0};
    trial    = {rem, nq[cdfa_pkg::DIV_BITS-1]};
    trial_ge = (trial >= {1'b0, vol});
    q_ext    = {5'd0, nq};

    // Product reduced to Q.24, rounded half up.
    prod_r = prod + 66'sd524288;
    red    = prod_r[65:20];

    sat_sum = {sum_sel[cdfa_pkg::SUM_W-1], sum_sel} + {{19{acc[cdfa_pkg::ACC_W-1]}}, acc};
    if (sat_sum[64] != sat_sum[63]) begin
      sat_val = sat_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      sat_val = sat_sum[63:0];
    end

    if (sum_sel > cdfa_pkg::CLAMP_POS) begin
      s_cl = cdfa_pkg::CLAMP_POS[51:0];
    end else if (sum_sel < cdfa_pkg::CLAMP_NEG) begin
      s_cl = cdfa_pkg::CLAMP_NEG[51:0];
    end else begin
      s_cl = sum_sel[51:0];
    end
    s_ext    = {{2{s_cl[51]}}, s_cl};
    self_ext = {{6{self_sel[cdfa_pkg::SELF_W-1]}}, self_sel};
    x_val    = cmd.demag ? ((s_ext <<< 1) - self_ext) : (s_ext + self_ext);
    x_abs    = x_val[53] ? (~x_val + 54'd1) : x_val;

    lo_sum = {1'b0, prod[63:0]} + (cmd.demag ? 65'h1_0000_0000 : 65'h0_8000_0000);
    r_sum  = prod[53:0] + {21'd0, lo_part};
    r_sh   = cmd.demag ? {1'b0, r_sum[53:1]} : r_sum;
    r_neg  = 54'd0 - r_sh;
    if (xneg) begin
      fin_val = (r_sh > 54'h0_8000_0000_0000) ? {1'b1, 47'd0} : r_neg[47:0];
    end else begin
      fin_val = (r_sh > 54'h0_7FFF_FFFF_FFFF) ? {1'b0, {47{1'b1}}} : r_sh[47:0];
    end
  end

  assign sts.div_last = (div_cnt == cdfa_pkg::CNT_W'(1));

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= mul_a * mul_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        neighbour_sum[i] <= '0;
        self_term[i]     <= '0;
      end
      div_cnt <= '0;
    end else begin
      case (cmd.op)
        cdfa_pkg::DP_DIV_LOAD: begin
          div_cnt <= cdfa_pkg::CNT_W'(cdfa_pkg::DIV_BITS);
        end
        cdfa_pkg::DP_DIV_STEP: begin
          div_cnt <= div_cnt - cdfa_pkg::CNT_W'(1);
        end
        cdfa_pkg::DP_SELF_WR: begin
          self_term[cmd.comp]     <= mag_sel[cdfa_pkg::MAG_W-1] ? (48'd0 - q_ext) : q_ext;
          neighbour_sum[cmd.comp] <= '0;
        end
        cdfa_pkg::DP_NB_SAT: begin
          neighbour_sum[cmd.comp] <= sat_val;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      cdfa_pkg::DP_CAPTURE: begin
        mag[0]  <= in_mag_x;
        mag[1]  <= in_mag_y;
        mag[2]  <= in_mag_z;
        vol     <= (in_volume == '0) ? cdfa_pkg::VOL_W'(1) : in_volume;
        tens[0] <= in_t_xx;
        tens[1] <= in_t_xy;
        tens[2] <= in_t_xz;
        tens[3] <= in_t_yy;
        tens[4] <= in_t_yz;
        tens[5] <= in_t_zz;
      end
      cdfa_pkg::DP_DIV_LOAD: begin
        nq  <= num_sum[62:20];
        rem <= '0;
      end
      cdfa_pkg::DP_DIV_STEP: begin
        if (trial_ge) begin
          rem <= cdfa_pkg::VOL_W'(trial - {1'b0, vol});
          nq  <= {nq[cdfa_pkg::DIV_BITS-2:0], 1'b1};
        end else begin
          rem <= trial[cdfa_pkg::VOL_W-1:0];
          nq  <= {nq[cdfa_pkg::DIV_BITS-2:0], 1'b0};
        end
      end
      cdfa_pkg::DP_NB_ACC: begin
        acc <= (cmd.col == 2'd0) ? red : (acc + red);
      end
      cdfa_pkg::DP_SC_PREP: begin
        xm   <= x_abs[cdfa_pkg::XM_W-1:0];
        xneg <= x_val[53];
      end
      cdfa_pkg::DP_SC_HI: begin
        lo_part <= lo_sum[64:32];
      end
      cdfa_pkg::DP_SC_FIN: begin
        if (cmd.demag) begin
          demag_out[cmd.comp] <= fin_val;
        end else begin
          field_out[cmd.comp] <= fin_val;
        end
      end
      default: begin
      end
    endcase
  end

  assign field_x = field_out[0];
  assign field_y = field_out[1];
  assign field_z = field_out[2];
  assign demag_x = demag_out[0];
  assign demag_y = demag_out[1];
  assign demag_z = demag_out[2];

endmodule

>>> hw/rtl/cell_dipole_field_accumulator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cell dipole field accumulator
// Forms the self term of a cell, sums dipole tensor terms from its neighbours
// and emits the scaled, saturated dipole and demagnetising fields.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Transaction
//   item      in          func, moment (Q16.16), volume, tensor (Q4.28)
//   result    out         field_x/y/z and demag_x/y/z (Q24.24, saturated)
//
// A start item occupies the block, for each component, for one multiply, one
// load, 43 steps of the one-bit-a-cycle divider by the volume and one write.
// A neighbour item passes its nine products one at a time through the single
// 33 by 33 multiplier. An end item, once the result register is free, forms
// each of its six outputs from two partial products of the scale factor. An
// item with the unused function code is accepted and leaves the sums, the self
// terms and the result unchanged.
// Reset clears the controller, the result valid flag, the neighbour sums and
// the self terms. A result that has not been taken holds in its register while
// the next item is accepted; an end item then waits until that register has
// been emptied before it starts scaling.
//
module cell_dipole_field_accumulator_top (
  input logic      clk,
  input logic      rst,
  cdfa_in_if.sink  item,
  cdfa_out_if.source result
);

  cdfa_pkg::cdfa_cmd_t cmd;
  cdfa_pkg::cdfa_sts_t sts;

  // The controller decides every step; the datapath only executes commands.
  cdfa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_func   (item.func),
    .in_ready  (item.ready),
    .out_ready (result.ready),
    .out_valid (result.valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  // The item fields are captured by the datapath in the cycle of acceptance.
  cdfa_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_mag_x  (item.mag_x),
    .in_mag_y  (item.mag_y),
    .in_mag_z  (item.mag_z),
    .in_volume (item.cell_volume),
    .in_t_xx   (item.t_xx),
    .in_t_xy   (item.t_xy),
    .in_t_xz   (item.t_xz),
    .in_t_yy   (item.t_yy),
    .in_t_yz   (item.t_yz),
    .in_t_zz   (item.t_zz),
    .field_x   (result.field_x),
    .field_y   (result.field_y),
    .field_z   (result.field_z),
    .demag_x   (result.demag_x),
    .demag_y   (result.demag_y),
    .demag_z   (result.demag_z)
  );

endmodule

>>> tb/cell_dipole_field_accumulator_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cell dipole field accumulator testbench
// Drives start, neighbour and end transactions into the accumulator, predicts
// the dipole and demagnetising fields of every end transaction with its own
// fixed-point model, and checks each result against the oldest prediction.
// ----------------------------------------------------------------------------
module cell_dipole_field_accumulator_top_test;

  // The fourth function code has no name in the package; the block ignores it.
  localparam logic [cdfa_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  localparam logic [31:0] WORD_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] WORD_MIN = 32'h8000_0000;

  localparam logic [cdfa_pkg::OUT_W-1:0] Q24_MAX     = 48'h7FFF_FFFF_FFFF;
  localparam logic [cdfa_pkg::OUT_W-1:0] Q24_MIN     = 48'h8000_0000_0000;
  localparam logic [63:0]      Q24_POS_LIM = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [63:0]      Q24_NEG_LIM = 64'h0000_8000_0000_0000;
  localparam longint           HALF_LSB_Q44 = 64'sd524288;

  localparam logic signed [cdfa_pkg::SUM_W-1:0] SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [cdfa_pkg::SUM_W-1:0] SUM_MIN = 64'sh8000_0000_0000_0000;

  localparam int     LONG_HOLD_CYCLES = 1000;
  localparam int     DRAIN_LIMIT      = 200000;
  localparam int     TAIL_CYCLES      = 300;
  localparam int     ITEM_TARGET      = 1750;
  localparam longint TIMEOUT_NS       = 20_000_000;

  typedef struct packed {
    logic [cdfa_pkg::FUNC_W-1:0]       func;
    logic signed [cdfa_pkg::MAG_W-1:0] mag_x;
    logic signed [cdfa_pkg::MAG_W-1:0] mag_y;
    logic signed [cdfa_pkg::MAG_W-1:0] mag_z;
    logic [cdfa_pkg::VOL_W-1:0]        vol;
    logic signed [cdfa_pkg::TEN_W-1:0] t_xx;
    logic signed [cdfa_pkg::TEN_W-1:0] t_xy;
    logic signed [cdfa_pkg::TEN_W-1:0] t_xz;
    logic signed [cdfa_pkg::TEN_W-1:0] t_yy;
    logic signed [cdfa_pkg::TEN_W-1:0] t_yz;
    logic signed [cdfa_pkg::TEN_W-1:0] t_zz;
  } cell_item_t;

  typedef struct packed {
    logic [cdfa_pkg::OUT_W-1:0] field_x;
    logic [cdfa_pkg::OUT_W-1:0] field_y;
    logic [cdfa_pkg::OUT_W-1:0] field_z;
    logic [cdfa_pkg::OUT_W-1:0] demag_x;
    logic [cdfa_pkg::OUT_W-1:0] demag_y;
    logic [cdfa_pkg::OUT_W-1:0] demag_z;
  } field_set_t;

  logic clk;
  logic rst;

  cdfa_in_if  item_ch ();
  cdfa_out_if result_ch ();

  cell_dipole_field_accumulator_top u_top (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  // Predicted state of the block: the running neighbour sums (Q40.24) and the
  // self term of the current cell (Q24.24). Both are zero after reset.
  logic signed [cdfa_pkg::SUM_W-1:0]  nb_sum   [3];
  logic signed [cdfa_pkg::SELF_W-1:0] self_fld [3];

  // Field sets predicted for end transactions that have not yet come out.
  field_set_t pending_fields [$];

  int  err_count       = 0;
  int  items_sent      = 0;
  int  ignored_items   = 0;
  int  cells_started   = 0;
  int  results_checked = 0;
  int  saturated_seen  = 0;

  // Idling controls. The main process owns the quiet flags and the hold
  // toggle; the ready generator owns its own counters.
  bit  src_quiet   = 1'b0;
  bit  sink_quiet  = 1'b0;
  bit  offering    = 1'b0;
  bit  hold_toggle = 1'b0;
  bit  hold_seen   = 1'b0;
  int  hold_left   = 0;
  int  stall_left  = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Fixed-point model of the block.
  // --------------------------------------------------------------------------

  // Self term of one component: 8*pi/(3V) times the moment, rounded half away
  // from zero. A zero volume counts as one cubic angstrom.
  function automatic logic signed [cdfa_pkg::SELF_W-1:0] self_component(
    input logic signed [cdfa_pkg::MAG_W-1:0] m,
    input logic [cdfa_pkg::VOL_W-1:0]        vol
  );
    longint                      sm;
    logic [63:0]                 mag;
    logic [63:0]                 den;
    logic [63:0]                 q;
    logic [cdfa_pkg::VOL_W-1:0]  v;
    logic signed [63:0]          res;
    sm  = longint'(m);
    mag = (sm < 0) ? -sm : sm;
    v   = (vol == '0) ? 24'd1 : vol;
    den = {20'd0, v, 20'd0};
    q   = (mag * {32'd0, cdfa_pkg::SELF_K} + (den >> 1)) / den;
    res = (sm < 0) ? -$signed(q) : $signed(q);
    return res[cdfa_pkg::SELF_W-1:0];
  endfunction

  // Adds with saturation at the signed 64-bit limits.
  function automatic logic signed [cdfa_pkg::SUM_W-1:0] add_saturated(
    input logic signed [cdfa_pkg::SUM_W-1:0] a,
    input logic signed [cdfa_pkg::SUM_W-1:0] b
  );
    logic [cdfa_pkg::SUM_W:0] w;
    w = {a[cdfa_pkg::SUM_W-1], a} + {b[cdfa_pkg::SUM_W-1], b};
    if (w[cdfa_pkg::SUM_W] != w[cdfa_pkg::SUM_W-1]) return w[cdfa_pkg::SUM_W] ? SUM_MIN : SUM_MAX;
    return w[cdfa_pkg::SUM_W-1:0];
  endfunction

  // Multiplies by the Bohr magneton scale and shifts by 32, or by 33 for the
  // demagnetising field, rounding half away from zero and saturating to Q24.24.
  function automatic logic [cdfa_pkg::OUT_W-1:0] scale_to_q24(input longint x, input bit halve);
    logic [63:0]  mag;
    logic [63:0]  r;
    logic [63:0]  neg;
    logic [127:0] prod;
    mag  = (x < 0) ? -x : x;
    prod = {64'd0, mag} * {96'd0, cdfa_pkg::SCALE_K} +
           (halve ? (128'd1 << 32) : (128'd1 << 31));
    r    = halve ? prod[96:33] : prod[95:32];
    if (x < 0) begin
      if (r > Q24_NEG_LIM) return Q24_MIN;
      neg = 64'd0 - r;
      return neg[cdfa_pkg::OUT_W-1:0];
    end
    if (r > Q24_POS_LIM) return Q24_MAX;
    return r[cdfa_pkg::OUT_W-1:0];
  endfunction

  // Updates the predicted state for one accepted transaction and, for an end
  // transaction, queues the field set that it should produce.
  task automatic apply_item(input cell_item_t it);
    logic signed [cdfa_pkg::MAG_W-1:0] mv [3];
    logic signed [cdfa_pkg::TEN_W-1:0] tr [3][3];
    logic [cdfa_pkg::OUT_W-1:0]        fo [3];
    logic [cdfa_pkg::OUT_W-1:0]        dm [3];
    longint                  row_sum;
    longint                  p;
    longint                  s;
    longint                  sf;
    field_set_t              fs;
    mv[0] = it.mag_x;
    mv[1] = it.mag_y;
    mv[2] = it.mag_z;
    tr[0][0] = it.t_xx; tr[0][1] = it.t_xy; tr[0][2] = it.t_xz;
    tr[1][0] = it.t_xy; tr[1][1] = it.t_yy; tr[1][2] = it.t_yz;
    tr[2][0] = it.t_xz; tr[2][1] = it.t_yz; tr[2][2] = it.t_zz;
    case (it.func)
      cdfa_pkg::FUNC_START: begin
        for (int i = 0; i < 3; i++) begin
          self_fld[i] = self_component(mv[i], it.vol);
          nb_sum[i]   = '0;
        end
      end
      cdfa_pkg::FUNC_NEIGH: begin
        // Each Q20.44 product is brought to Q.24 rounding half up, then the
        // row is added to the running sum.
        for (int i = 0; i < 3; i++) begin
          row_sum = 0;
          for (int j = 0; j < 3; j++) begin
            p = longint'(mv[j]) * longint'(tr[i][j]);
            row_sum += (p + HALF_LSB_Q44) >>> 20;
          end
          nb_sum[i] = add_saturated(nb_sum[i], row_sum);
        end
      end
      cdfa_pkg::FUNC_END: begin
        for (int i = 0; i < 3; i++) begin
          s = nb_sum[i];
          if (s > cdfa_pkg::CLAMP_POS) s = cdfa_pkg::CLAMP_POS;
          else if (s < cdfa_pkg::CLAMP_NEG) s = cdfa_pkg::CLAMP_NEG;
          sf = longint'(self_fld[i]);
          fo[i] = scale_to_q24(s + sf, 1'b0);
          dm[i] = scale_to_q24(2 * s - sf, 1'b1);
        end
        fs.field_x = fo[0];
        fs.field_y = fo[1];
        fs.field_z = fo[2];
        fs.demag_x = dm[0];
        fs.demag_y = dm[1];
        fs.demag_z = dm[2];
        pending_fields.push_back(fs);
      end
      default: ;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Reporting and checking.
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    err_count++;
    $display("mismatch at %0t ns: %s", $time, msg);
  endtask

  task automatic check_component(
    input string            name,
    input logic [cdfa_pkg::OUT_W-1:0] got,
    input logic [cdfa_pkg::OUT_W-1:0] want
  );
    if (got !== want)
      report_mismatch($sformatf("%s got %h, predicted %h", name, got, want));
  endtask

  // Every result transaction is taken against the oldest prediction. Outputs
  // are sampled at the clock edge, before any update of that edge lands.
  always @(posedge clk) begin
    field_set_t want;
    if (!rst && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
      if (pending_fields.size() == 0) begin
        report_mismatch("result transaction with no field set predicted");
      end else begin
        want = pending_fields.pop_front();
        results_checked++;
        if (want.field_x == Q24_MAX || want.field_x == Q24_MIN ||
            want.demag_x == Q24_MAX || want.demag_x == Q24_MIN ||
            want.field_y == Q24_MAX || want.field_y == Q24_MIN ||
            want.demag_y == Q24_MAX || want.demag_y == Q24_MIN ||
            want.field_z == Q24_MAX || want.field_z == Q24_MIN ||
            want.demag_z == Q24_MAX || want.demag_z == Q24_MIN)
          saturated_seen++;
        check_component("field_x", result_ch.field_x, want.field_x);
        check_component("field_y", result_ch.field_y, want.field_y);
        check_component("field_z", result_ch.field_z, want.field_z);
        check_component("demag_x", result_ch.demag_x, want.demag_x);
        check_component("demag_y", result_ch.demag_y, want.demag_y);
        check_component("demag_z", result_ch.demag_z, want.demag_z);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Random helpers.
  // --------------------------------------------------------------------------

  // Idle lengths: mostly none, sometimes short, rarely a long gap.
  function automatic int pick_gap(input bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_neighbours();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(0, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(11, 20);
  endfunction

  // A 32-bit word biased towards the extremes, zero and small magnitudes.
  function automatic logic [31:0] rand_word();
    logic [31:0] small_val;
    small_val = $urandom_range(0, 32'h0003_FFFF);
    case ($urandom_range(0, 9))
      0:       return WORD_MIN;
      1:       return WORD_MAX;
      2:       return '0;
      3:       return small_val;
      4:       return -small_val;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [cdfa_pkg::VOL_W-1:0] rand_volume();
    logic [31:0] w;
    w = $urandom();
    case ($urandom_range(0, 19))
      0:         return '0;
      1:         return '1;
      2, 3, 4, 5,
      6, 7, 8, 9: return cdfa_pkg::VOL_W'($urandom_range(1, 64));
      default:   return w[cdfa_pkg::VOL_W-1:0];
    endcase
  endfunction

  // Every field is filled, including those the given function code ignores.
  function automatic cell_item_t random_item(input logic [cdfa_pkg::FUNC_W-1:0] f);
    cell_item_t it;
    it.func  = f;
    it.mag_x = rand_word();
    it.mag_y = rand_word();
    it.mag_z = rand_word();
    it.vol   = rand_volume();
    it.t_xx  = rand_word();
    it.t_xy  = rand_word();
    it.t_xz  = rand_word();
    it.t_yy  = rand_word();
    it.t_yz  = rand_word();
    it.t_zz  = rand_word();
    return it;
  endfunction

  function automatic cell_item_t with_moment(input cell_item_t it, input logic [31:0] v);
    it.mag_x = v;
    it.mag_y = v;
    it.mag_z = v;
    return it;
  endfunction

  function automatic cell_item_t with_tensor(input cell_item_t it, input logic [31:0] v);
    it.t_xx = v;
    it.t_xy = v;
    it.t_xz = v;
    it.t_yy = v;
    it.t_yz = v;
    it.t_zz = v;
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // Result ready generator. It idles at random, and when the main process
  // flips the hold toggle it keeps ready low for a long, counted stretch so
  // that the result register stays full and the next end item stalls the input.
  // --------------------------------------------------------------------------
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        result_ch.ready <= 1'b0;
      end else if (hold_toggle != hold_seen) begin
        hold_seen = hold_toggle;
        hold_left = LONG_HOLD_CYCLES;
        result_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
        if ($urandom_range(0, 2) == 0) stall_left = pick_gap(sink_quiet);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus.
  // --------------------------------------------------------------------------

  // Offers one transaction and holds it until the block takes it. Valid stays
  // high into the next transaction unless a gap is drawn. The task is always
  // entered just after a rising edge.
  task automatic send_item(input cell_item_t it);
    int gap;
    item_ch.valid       <= 1'b1;
    item_ch.func        <= it.func;
    item_ch.mag_x       <= it.mag_x;
    item_ch.mag_y       <= it.mag_y;
    item_ch.mag_z       <= it.mag_z;
    item_ch.cell_volume <= it.vol;
    item_ch.t_xx        <= it.t_xx;
    item_ch.t_xy        <= it.t_xy;
    item_ch.t_xz        <= it.t_xz;
    item_ch.t_yy        <= it.t_yy;
    item_ch.t_yz        <= it.t_yz;
    item_ch.t_zz        <= it.t_zz;
    offering = 1'b1;
    do @(posedge clk); while (item_ch.ready !== 1'b1);
    apply_item(it);
    if (it.func == FUNC_UNUSED) ignored_items++;
    else items_sent++;
    if (it.func == cdfa_pkg::FUNC_START) cells_started++;
    gap = pick_gap(src_quiet);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      offering = 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Withdraws any offer and waits until every predicted field set has come.
  // A withdrawn offer is seen low by the block before the wait begins.
  task automatic wait_drained();
    int n;
    n = 0;
    if (offering) begin
      item_ch.valid <= 1'b0;
      offering = 1'b0;
      @(posedge clk);
    end
    while (pending_fields.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    if (pending_fields.size() != 0)
      report_mismatch($sformatf("%0d field sets never came out",
                                pending_fields.size()));
  endtask

  // One well-formed cell: start, a number of neighbours, end.
  task automatic send_cell(input int n_neigh);
    send_item(random_item(cdfa_pkg::FUNC_START));
    repeat (n_neigh) send_item(random_item(cdfa_pkg::FUNC_NEIGH));
    send_item(random_item(cdfa_pkg::FUNC_END));
  endtask

  // Field and code extremes, the rounding corners and the special cases:
  // an end straight after reset, ignored codes, zero and full volume, and
  // repeated ends with accumulation carrying on past an end.
  task automatic test_directed();
    cell_item_t it;
    send_item(random_item(cdfa_pkg::FUNC_END));
    send_item(random_item(FUNC_UNUSED));
    send_item(random_item(cdfa_pkg::FUNC_END));

    it = random_item(cdfa_pkg::FUNC_START);
    it.mag_x = WORD_MAX;
    it.mag_y = WORD_MIN;
    it.mag_z = '0;
    it.vol   = '0;
    send_item(it);
    send_item(random_item(cdfa_pkg::FUNC_END));

    it = random_item(cdfa_pkg::FUNC_START);
    it.mag_x = WORD_MIN;
    it.mag_y = 32'sd1;
    it.mag_z = -32'sd1;
    it.vol   = 24'd1;
    send_item(it);
    send_item(with_tensor(with_moment(random_item(cdfa_pkg::FUNC_NEIGH), WORD_MIN),
                          WORD_MIN));
    send_item(with_tensor(with_moment(random_item(cdfa_pkg::FUNC_NEIGH), WORD_MAX),
                          WORD_MAX));
    it = random_item(cdfa_pkg::FUNC_NEIGH);
    it.mag_x = WORD_MIN;
    it.mag_y = WORD_MAX;
    it.mag_z = 32'sd1;
    it.t_xx  = WORD_MAX;
    it.t_xy  = WORD_MIN;
    it.t_xz  = 32'sd1;
    it.t_yy  = -32'sd1;
    it.t_yz  = '0;
    it.t_zz  = WORD_MIN;
    send_item(it);
    send_item(random_item(cdfa_pkg::FUNC_END));
    send_item(random_item(cdfa_pkg::FUNC_END));
    send_item(random_item(cdfa_pkg::FUNC_NEIGH));
    send_item(random_item(FUNC_UNUSED));
    send_item(random_item(cdfa_pkg::FUNC_END));

    it = random_item(cdfa_pkg::FUNC_START);
    it.vol = '1;
    send_item(it);
    // Products of exactly half an output LSB, either sign, and one of a full LSB.
    it = random_item(cdfa_pkg::FUNC_NEIGH);
    it.mag_x = 32'sd1;
    it.mag_y = -32'sd1;
    it.mag_z = 32'sd1;
    it.t_xx  = 32'sd524288;
    it.t_xy  = 32'sd524288;
    it.t_xz  = -32'sd524288;
    it.t_yy  = 32'sd524288;
    it.t_yz  = -32'sd524288;
    it.t_zz  = 32'sd1048576;
    send_item(it);
    send_item(random_item(cdfa_pkg::FUNC_END));

    it = random_item(cdfa_pkg::FUNC_START);
    it.mag_x = 32'sd1;
    it.mag_y = -32'sd1;
    it.mag_z = '0;
    it.vol   = 24'd3;
    send_item(it);
    send_item(random_item(cdfa_pkg::FUNC_END));
    wait_drained();
  endtask

  // Sums large enough to saturate both fields either way, and one long cell
  // whose sum passes the clamp before scaling.
  task automatic test_saturation();
    send_item(with_moment(random_item(cdfa_pkg::FUNC_START), '0));
    repeat (14)
      send_item(with_tensor(with_moment(random_item(cdfa_pkg::FUNC_NEIGH), WORD_MIN),
                            WORD_MIN));
    send_item(random_item(cdfa_pkg::FUNC_END));

    send_item(with_moment(random_item(cdfa_pkg::FUNC_START), '0));
    repeat (14)
      send_item(with_tensor(with_moment(random_item(cdfa_pkg::FUNC_NEIGH), WORD_MIN),
                            WORD_MAX));
    send_item(random_item(cdfa_pkg::FUNC_END));

    send_item(with_moment(random_item(cdfa_pkg::FUNC_START), WORD_MAX));
    repeat (110)
      send_item(with_tensor(with_moment(random_item(cdfa_pkg::FUNC_NEIGH), WORD_MIN),
                            WORD_MIN));
    send_item(random_item(cdfa_pkg::FUNC_END));
    wait_drained();
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering
  // cells back to back; the sender then pauses until everything has come out.
  task automatic test_output_hold();
    hold_toggle <= ~hold_toggle;
    src_quiet = 1'b1;
    repeat (4) send_cell(2);
    src_quiet = 1'b0;
    wait_drained();
  endtask

  // A stretch with no idling on either side.
  task automatic test_streaming();
    int first;
    first      = items_sent;
    src_quiet  = 1'b1;
    sink_quiet = 1'b1;
    while (items_sent - first < 150) send_cell(pick_neighbours());
    src_quiet  = 1'b0;
    sink_quiet = 1'b0;
    wait_drained();
  endtask

  // Mostly well-formed cells with random content; the rest is ignored codes,
  // lone ends, abandoned cells and stray neighbours. Every couple of hundred
  // transactions the sender waits for the block to empty.
  task automatic test_random_cells(input int target);
    int r;
    int last_pause;
    last_pause = items_sent;
    while (items_sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 78) begin
        send_cell(pick_neighbours());
        if ($urandom_range(0, 9) == 0) begin
          send_item(random_item(cdfa_pkg::FUNC_END));
          repeat ($urandom_range(0, 3)) send_item(random_item(cdfa_pkg::FUNC_NEIGH));
          send_item(random_item(cdfa_pkg::FUNC_END));
        end
      end else if (r < 86) begin
        repeat ($urandom_range(1, 3)) send_item(random_item(FUNC_UNUSED));
      end else if (r < 92) begin
        send_item(random_item(cdfa_pkg::FUNC_END));
      end else if (r < 96) begin
        send_item(random_item(cdfa_pkg::FUNC_START));
        repeat ($urandom_range(0, 4)) send_item(random_item(cdfa_pkg::FUNC_NEIGH));
      end else begin
        send_item(random_item(cdfa_pkg::FUNC_NEIGH));
      end
      if (items_sent - last_pause >= 200) begin
        wait_drained();
        last_pause = items_sent;
      end
    end
    wait_drained();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence. All inputs start at known values; reset is held once at the
  // start and then the tests run in turn.
  // --------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < 3; i++) begin
      nb_sum[i]   = '0;
      self_fld[i] = '0;
    end
    rst                 <= 1'b1;
    item_ch.valid       <= 1'b0;
    item_ch.func        <= cdfa_pkg::FUNC_START;
    item_ch.mag_x       <= '0;
    item_ch.mag_y       <= '0;
    item_ch.mag_z       <= '0;
    item_ch.cell_volume <= '0;
    item_ch.t_xx        <= '0;
    item_ch.t_xy        <= '0;
    item_ch.t_xz        <= '0;
    item_ch.t_yy        <= '0;
    item_ch.t_yz        <= '0;
    item_ch.t_zz        <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_saturation();
    test_output_hold();
    test_streaming();
    test_random_cells(ITEM_TARGET);

    // Leave room for any stray result after the last expected one.
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d cells in %0d transactions, plus %0d ignored-code transactions.",
             cells_started, items_sent, ignored_items);
    $display("Checked %0d field sets, %0d of them with a saturated component; %0d mismatches.",
             results_checked, saturated_seen, err_count);
    if (err_count == 0) begin
      $display("[cell_dipole_field_accumulator_top] OK");
    end else begin
      $display("[cell_dipole_field_accumulator_top] ERROR");
    end
    $finish;
  end

  // Safety net well beyond the slowest correct run.
  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d field sets outstanding", pending_fields.size());
    $display("[cell_dipole_field_accumulator_top] ERROR");
    $finish;
  end

endmodule
